// ===== hdl/stwu_pkg.sv =====
// Shared types, constants and sizes for the scalable window update block.
package stwu_pkg;

  // Widths of the fields carried by the channels.
  localparam int unsigned CmdWidth = 1;
  localparam int unsigned SegWidth = 16;
  localparam int unsigned ByteWidth = 32;
  localparam int unsigned CfgWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  // Default for the window width parameter of the top level.
  localparam int unsigned CwndBitsDefault = 16;

  // Event kinds.
  localparam logic CmdAck = 1'b0;
  localparam logic CmdLoss = 1'b1;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIndexWidth-1:0] {
    CfgAiFactor = 2'd0,
    CfgMdFactor = 2'd1,
    CfgSegSize  = 2'd2
  } cfg_reg_e;

  // Register reset values.
  localparam logic [CfgWidth-1:0] AiFactorReset = 16'd100;
  localparam logic [CfgWidth-1:0] MdFactorReset = 16'd6554;
  localparam logic [CfgWidth-1:0] SegSizeReset = 16'd536;

  // Arithmetic constants.
  localparam logic [CfgWidth-1:0] MdCapQ16 = 16'd4096;
  localparam logic [CfgWidth:0] Q16One = 17'h10000;
  localparam logic [ByteWidth-1:0] MinSsthreshSeg = 32'd2;
  localparam logic [SegWidth-1:0] AiDivisor = 16'd10;

  // Serial divider: dividend and quotient share one shift register.
  localparam int unsigned DivWidth = 32;
  localparam int unsigned DivisorWidth = 16;
  localparam int unsigned DivCntWidth = $clog2(DivWidth + 1);
  localparam logic [DivCntWidth-1:0] DivStepsCwnd = DivCntWidth'(SegWidth);
  localparam logic [DivCntWidth-1:0] DivStepsCount = DivCntWidth'(SegWidth + 1);
  localparam logic [DivCntWidth-1:0] DivStepsBytes = DivCntWidth'(ByteWidth);

  // Serial shift-add multiplier.
  localparam int unsigned MulAWidth = 32;
  localparam int unsigned MulBWidth = 17;
  localparam int unsigned ProdWidth = MulAWidth + MulBWidth;
  localparam int unsigned MulCntWidth = $clog2(MulBWidth + 1);

  typedef struct packed {
    logic                    cmd;
    logic [SegWidth-1:0]     cwnd_segments;
    logic [SegWidth-1:0]     segments_acked;
    logic [ByteWidth-1:0]    bytes_in_flight;
  } in_item_t;

  typedef struct packed {
    logic [SegWidth-1:0]     new_cwnd_segments;
    logic [ByteWidth-1:0]    cwnd_bytes;
    logic                    cwnd_changed;
    logic [ByteWidth-1:0]    ssthresh_bytes;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic [DivCntWidth-1:0]  steps;
    logic [DivWidth-1:0]     dividend;
    logic [DivisorWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    start;
    logic [MulAWidth-1:0]    a;
    logic [MulBWidth-1:0]    b;
  } mul_req_t;

endpackage

// ===== hdl/scalable_tcp_window_update_top.sv =====
// Top level of the scalable window update: sequencer, registers and output stage.
// An ack request divides the ack count by the threshold only when the count has
// reached it. Requests are handled one at a time; the pace is set by the bit-serial
// divider (one quotient bit a cycle) and multiplier. Reset (asynchronous, active low)
// clears the pending ack count, loads the register defaults and empties the output
// register; no clearing pass is needed.
module scalable_tcp_window_update_top #(
  parameter int unsigned CWND_BITS = stwu_pkg::CwndBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  stwu_pkg::in_item_t                     in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output stwu_pkg::out_item_t                    out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [stwu_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [stwu_pkg::CfgWidth-1:0]          cfg_data_i
);

  // The window saturates at the smaller of 2^CWND_BITS - 1 and the field maximum.
  localparam int unsigned LimBits =
    (CWND_BITS < stwu_pkg::SegWidth) ? CWND_BITS : stwu_pkg::SegWidth;
  localparam logic [stwu_pkg::SegWidth-1:0] CwndLimit =
    stwu_pkg::SegWidth'((33'd1 << LimBits) - 33'd1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIV10 = 10'b0000000010,
    S_MULG  = 10'b0000000100,
    S_WCALC = 10'b0000001000,
    S_DIVW  = 10'b0000010000,
    S_MULC  = 10'b0000100000,
    S_DIVS  = 10'b0001000000,
    S_MULF  = 10'b0010000000,
    S_MULT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [stwu_pkg::CfgWidth-1:0]   ai_q, md_q, ss_q;

  // Pending ack count, the only state that lives across requests.
  logic [stwu_pkg::SegWidth-1:0]   pend_q, pend_d;

  // Working registers of the request in flight.
  logic                            cmd_q, cmd_d;
  logic [stwu_pkg::SegWidth-1:0]   cwnd_q, cwnd_d;
  logic [stwu_pkg::SegWidth-1:0]   acked_q, acked_d;
  logic [stwu_pkg::SegWidth-1:0]   w_q, w_d;
  logic [stwu_pkg::SegWidth:0]     cnt_q, cnt_d;
  logic                            inc1_q, inc1_d;
  logic [stwu_pkg::SegWidth-1:0]   newc_q, newc_d;
  logic                            changed_q, changed_d;
  logic [stwu_pkg::ByteWidth-1:0]  ssth_q, ssth_d;
  logic [stwu_pkg::ByteWidth-1:0]  bytes_q, bytes_d;

  // Output register, which lets a new request in while a result waits.
  logic                            out_valid_q, out_valid_d;
  stwu_pkg::out_item_t             out_data_q, out_data_d;
  logic                            load_out;

  // Shared arithmetic units.
  stwu_pkg::div_req_t              div_req;
  logic                            div_done;
  logic [stwu_pkg::DivWidth-1:0]   div_quo;
  stwu_pkg::mul_req_t              mul_req;
  logic                            mul_done;
  logic [stwu_pkg::ProdWidth-1:0]  mul_prod;

  // Corrected inputs: a zero window counts as one segment, a zero segment
  // size as one byte, and the window is clamped to the limit.
  logic [stwu_pkg::SegWidth-1:0]   cwnd_nz;
  logic [stwu_pkg::SegWidth-1:0]   cwnd_in;
  logic [stwu_pkg::SegWidth-1:0]   ss_used;

  // Ack threshold and count update.
  logic [stwu_pkg::ByteWidth-1:0]  grow;
  logic [stwu_pkg::SegWidth-1:0]   w_new;
  logic                            inc1_new;

  // Window growth: input window, plus one when the old count was full,
  // plus the quotient of count over threshold.
  logic [stwu_pkg::SegWidth:0]     add_quo;
  logic [stwu_pkg::SegWidth+1:0]   newc_sum;
  logic [stwu_pkg::SegWidth-1:0]   newc_sat;

  // Loss path: decrease factor and threshold in segments.
  logic [stwu_pkg::CfgWidth-1:0]   md_cap;
  logic [stwu_pkg::CfgWidth:0]     keep_frac;
  logic [stwu_pkg::ByteWidth-1:0]  thr;
  logic [stwu_pkg::ByteWidth-1:0]  thr_min;

  stwu_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  stwu_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Configuration writes are taken in any cycle; an unknown index is ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ai_q <= stwu_pkg::AiFactorReset;
      md_q <= stwu_pkg::MdFactorReset;
      ss_q <= stwu_pkg::SegSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        stwu_pkg::CfgAiFactor: begin
          ai_q <= cfg_data_i;
        end
        stwu_pkg::CfgMdFactor: begin
          md_q <= cfg_data_i;
        end
        stwu_pkg::CfgSegSize: begin
          ss_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign cwnd_nz = (in_data_i.cwnd_segments == '0) ? stwu_pkg::SegWidth'(1)
                                                   : in_data_i.cwnd_segments;
  assign cwnd_in = (cwnd_nz > CwndLimit) ? CwndLimit : cwnd_nz;
  assign ss_used = (ss_q == '0) ? stwu_pkg::CfgWidth'(1) : ss_q;

  // The threshold is the window when ai_factor * floor(cwnd / 10) reaches it,
  // otherwise that product, but never below one.
  always_comb begin
    grow = mul_prod[stwu_pkg::ByteWidth-1:0];
    if (grow == '0) begin
      grow = stwu_pkg::ByteWidth'(1);
    end
    w_new = ({16'd0, cwnd_q} < grow) ? cwnd_q : grow[stwu_pkg::SegWidth-1:0];
    inc1_new = pend_q >= w_new;
  end

  assign add_quo = (state_q == S_DIVW) ? div_quo[stwu_pkg::SegWidth:0] : '0;
  assign newc_sum = {2'b00, cwnd_q} + {{(stwu_pkg::SegWidth + 1){1'b0}}, inc1_q}
                  + {1'b0, add_quo};
  assign newc_sat = (newc_sum > {2'b00, CwndLimit}) ? CwndLimit
                                                   : newc_sum[stwu_pkg::SegWidth-1:0];

  // The decrease factor is capped at 1/16, so at least 15/16 of the
  // segments in flight stay in the threshold.
  assign md_cap = (md_q < stwu_pkg::MdCapQ16) ? md_q : stwu_pkg::MdCapQ16;
  assign keep_frac = stwu_pkg::Q16One - {1'b0, md_cap};
  assign thr = mul_prod[stwu_pkg::ByteWidth+15:16];
  assign thr_min = (thr < stwu_pkg::MinSsthreshSeg) ? stwu_pkg::MinSsthreshSeg : thr;

  always_comb begin
    state_d = state_q;
    pend_d = pend_q;
    cmd_d = cmd_q;
    cwnd_d = cwnd_q;
    acked_d = acked_q;
    w_d = w_q;
    cnt_d = cnt_q;
    inc1_d = inc1_q;
    newc_d = newc_q;
    changed_d = changed_q;
    ssth_d = ssth_q;
    bytes_d = bytes_q;
    div_req = '0;
    mul_req = '0;
    load_out = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_data_i.cmd;
          cwnd_d = cwnd_in;
          acked_d = in_data_i.segments_acked;
          div_req.start = 1'b1;
          if (in_data_i.cmd == stwu_pkg::CmdAck) begin
            // floor(cwnd / 10): the window sits in the top half of the dividend.
            div_req.steps = stwu_pkg::DivStepsCwnd;
            div_req.dividend = {cwnd_in, 16'd0};
            div_req.divisor = stwu_pkg::AiDivisor;
            state_d = S_DIV10;
          end else begin
            // Whole segments in flight.
            div_req.steps = stwu_pkg::DivStepsBytes;
            div_req.dividend = in_data_i.bytes_in_flight;
            div_req.divisor = ss_used;
            state_d = S_DIVS;
          end
        end
      end

      S_DIV10: begin
        if (div_done) begin
          mul_req.start = 1'b1;
          mul_req.a = {16'd0, ai_q};
          mul_req.b = {1'b0, div_quo[stwu_pkg::SegWidth-1:0]};
          state_d = S_MULG;
        end
      end

      S_MULG: begin
        if (mul_done) begin
          // A count that already reached the threshold is spent on one
          // segment of growth before the new acks are added.
          w_d = w_new;
          inc1_d = inc1_new;
          cnt_d = (inc1_new ? '0 : {1'b0, pend_q}) + {1'b0, acked_q};
          state_d = S_WCALC;
        end
      end

      S_WCALC: begin
        if (cnt_q >= {1'b0, w_q}) begin
          div_req.start = 1'b1;
          div_req.steps = stwu_pkg::DivStepsCount;
          div_req.dividend = {cnt_q, 15'd0};
          div_req.divisor = w_q;
          state_d = S_DIVW;
        end else begin
          pend_d = cnt_q[stwu_pkg::SegWidth-1:0];
          newc_d = newc_sat;
          changed_d = newc_sat != cwnd_q;
          ssth_d = '0;
          mul_req.start = 1'b1;
          mul_req.a = {16'd0, ss_used};
          mul_req.b = {1'b0, newc_sat};
          state_d = S_MULC;
        end
      end

      S_DIVW: begin
        if (div_done) begin
          pend_d = '0;
          newc_d = newc_sat;
          changed_d = newc_sat != cwnd_q;
          ssth_d = '0;
          mul_req.start = 1'b1;
          mul_req.a = {16'd0, ss_used};
          mul_req.b = {1'b0, newc_sat};
          state_d = S_MULC;
        end
      end

      S_DIVS: begin
        if (div_done) begin
          mul_req.start = 1'b1;
          mul_req.a = div_quo;
          mul_req.b = keep_frac;
          state_d = S_MULF;
        end
      end

      S_MULF: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a = thr_min;
          mul_req.b = {1'b0, ss_used};
          state_d = S_MULT;
        end
      end

      S_MULT: begin
        if (mul_done) begin
          // Threshold in bytes saturates at the field maximum.
          ssth_d = (mul_prod[stwu_pkg::ProdWidth-1:stwu_pkg::ByteWidth] != '0)
                 ? '1 : mul_prod[stwu_pkg::ByteWidth-1:0];
          newc_d = cwnd_q;
          changed_d = 1'b0;
          mul_req.start = 1'b1;
          mul_req.a = {16'd0, ss_used};
          mul_req.b = {1'b0, cwnd_q};
          state_d = S_MULC;
        end
      end

      S_MULC: begin
        if (mul_done) begin
          // Two 16-bit factors cannot overflow the byte field.
          bytes_d = mul_prod[stwu_pkg::ByteWidth-1:0];
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d = out_data_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d.new_cwnd_segments = newc_q;
      out_data_d.cwnd_bytes = bytes_q;
      out_data_d.cwnd_changed = changed_q;
      out_data_d.ssthresh_bytes = ssth_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cwnd_q <= cwnd_d;
    acked_q <= acked_d;
    w_q <= w_d;
    cnt_q <= cnt_d;
    inc1_q <= inc1_d;
    newc_q <= newc_d;
    changed_q <= changed_d;
    ssth_q <= ssth_d;
    bytes_q <= bytes_d;
    out_data_q <= out_data_d;
  end

  // A request is taken only while the sequencer is idle; the output
  // register decouples this from the downstream stall.
  assign in_stall_o = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  // A loss request never touches the pending ack count.
  ap_loss_keeps_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && cmd_q == stwu_pkg::CmdLoss) |=> $stable(pend_q))
    else $error("pending ack count changed during a loss request");

  // The ack threshold is never zero and never above the window.
  ap_threshold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WCALC) |-> (w_q != '0 && w_q <= cwnd_q))
    else $error("ack threshold out of range");

  // A finished result only grows the window, within the limit, and the
  // changed flag agrees with the values.
  ap_window_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |->
      (newc_q <= CwndLimit && newc_q >= cwnd_q && changed_q == (newc_q != cwnd_q)))
    else $error("inconsistent window result");

  // Ack results carry no threshold.
  ap_ack_no_ssthresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cmd_q == stwu_pkg::CmdAck) |-> ssth_q == '0)
    else $error("ack result with nonzero threshold");

endmodule

// ===== hdl/stwu_serial_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module stwu_serial_div (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  stwu_pkg::div_req_t                     req_i,
  output logic                                   done_o,
  output logic [stwu_pkg::DivWidth-1:0]          quo_o
);

  logic [stwu_pkg::DivWidth-1:0]        quo_q, quo_d;
  logic [stwu_pkg::DivisorWidth:0]      rem_q, rem_d;
  logic [stwu_pkg::DivisorWidth-1:0]    div_q, div_d;
  logic [stwu_pkg::DivCntWidth-1:0]     cnt_q, cnt_d;
  logic                                 done_q, done_d;
  logic [stwu_pkg::DivisorWidth:0]      shifted;
  logic [stwu_pkg::DivisorWidth:0]      diff;
  logic                                 ge;

  // The dividend is aligned to the top of the register, so the quotient
  // fills the low bits as the dividend leaves at the top.
  assign shifted = {rem_q[stwu_pkg::DivisorWidth-1:0], quo_q[stwu_pkg::DivWidth-1]};
  assign diff = shifted - {1'b0, div_q};
  assign ge = shifted >= {1'b0, div_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      div_d = req_i.divisor;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff : shifted;
      quo_d = {quo_q[stwu_pkg::DivWidth-2:0], ge};
      cnt_d = cnt_q - stwu_pkg::DivCntWidth'(1);
      done_d = cnt_q == stwu_pkg::DivCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;

endmodule

// ===== hdl/stwu_serial_mul.sv =====
// Shift-add multiplier that consumes one multiplier bit per cycle.
module stwu_serial_mul (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  stwu_pkg::mul_req_t                     req_i,
  output logic                                   done_o,
  output logic [stwu_pkg::ProdWidth-1:0]         prod_o
);

  logic [stwu_pkg::ProdWidth-1:0]       prod_q, prod_d;
  logic [stwu_pkg::MulAWidth-1:0]       a_q, a_d;
  logic [stwu_pkg::MulCntWidth-1:0]     cnt_q, cnt_d;
  logic                                 done_q, done_d;
  logic [stwu_pkg::MulAWidth:0]         sum;

  // The multiplier sits in the low bits and shifts out as the partial
  // sum shifts in from the top.
  assign sum = {1'b0, prod_q[stwu_pkg::ProdWidth-1:stwu_pkg::MulBWidth]}
             + (prod_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    prod_d = prod_q;
    a_d = a_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      prod_d = {{stwu_pkg::MulAWidth{1'b0}}, req_i.b};
      a_d = req_i.a;
      cnt_d = stwu_pkg::MulCntWidth'(stwu_pkg::MulBWidth);
    end else if (cnt_q != '0) begin
      prod_d = {sum, prod_q[stwu_pkg::MulBWidth-1:1]};
      cnt_d = cnt_q - stwu_pkg::MulCntWidth'(1);
      done_d = cnt_q == stwu_pkg::MulCntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a_q <= a_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule
